>>> hw/rtl/imp_pkg.sv
// Shared types and constants for the integer matrix power unit.
// No dependencies; imported by integer_matrix_power_unit and tb_top.

package imp_pkg;

  localparam int unsigned ELEM_W     = 32;  // matrix element width
  localparam int unsigned SIZE_W     = 4;   // matrix_size register width
  localparam int unsigned EXP_W      = 8;   // exponent register width
  localparam int unsigned CFG_IDX_W  = 1;   // register index width
  localparam int unsigned CFG_DATA_W = 8;   // widest register

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MATRIX_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_EXPONENT    = 1'b1;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd2;
  localparam logic [EXP_W-1:0]  EXP_RESET  = 8'd1;

  // sequencer states, one-hot
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,  // loading elements
    ST_MUL   = 5'b00010,  // issuing multiply-accumulate steps
    ST_DRAIN = 5'b00100,  // waiting for the MAC pipeline to empty
    ST_PRIME = 5'b01000,  // first result read in flight
    ST_EMIT  = 5'b10000   // streaming the result out
  } state_e;

endpackage

>>> hw/rtl/imp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the matrix stores of the power unit.

module imp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/integer_matrix_power_unit.sv
// Integer matrix power unit: top level, sequencer and shared MAC datapath.
// Depends on imp_pkg and imp_ram.
//
// Loads a square matrix A (matrix_size rows/cols, 0 read as 1, above MAX_DIM
// saturated) one element per input transfer, row-major, and after the final
// element streams A^exponent out row-major with tlast on the final element.
// Arithmetic wraps at 32 bits. Exponent 0 gives the identity matrix.
// The transfer that completes the matrix starts (exponent-1) multiply passes
// (none for exponent 0); each pass runs through the single 32x32 multiplier
// and accumulator (one product per cycle, limited by one read port on each
// matrix store) and then drains the MAC pipeline. The result then streams
// out at one element per cycle, subject to m_axis_tready, once the first
// result read, issued in the ST_PRIME state, has returned. The input
// is not ready from the completing transfer until the last result has been
// placed in the output register. Writes to matrix_size and exponent take
// effect at the next edge and belong in gaps where no transfer is in flight;
// a computation already started keeps the shape and exponent it latched, and
// the values in effect at the completing transfer are the ones used.

module integer_matrix_power_unit
  import imp_pkg::*;
#(
  parameter int unsigned MAX_DIM = 8  // largest matrix dimension, 1..15
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // element stream in
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [ELEM_W-1:0]     s_axis_tdata,   // [31:0] element_value
  // result stream out
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [ELEM_W-1:0]     m_axis_tdata,   // [31:0] result_value
  output logic                  m_axis_tlast    // last_element
);

  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned DIM_W = $clog2(MAX_DIM + 1);
  localparam int unsigned IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  // row-major linear address a*n+b
  function automatic logic [AW-1:0] lin_addr(input logic [IW-1:0]    a,
                                             input logic [IW-1:0]    b,
                                             input logic [DIM_W-1:0] n);
    lin_addr = AW'(a) * AW'(n) + AW'(b);
  endfunction

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [SIZE_W-1:0] size_q;
  logic [EXP_W-1:0]  exp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SIZE_RESET;
      exp_q  <= EXP_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MATRIX_SIZE: size_q <= cfg_data_i[SIZE_W-1:0];
        REG_EXPONENT:    exp_q  <= cfg_data_i[EXP_W-1:0];
        default: ;
      endcase
    end
  end

  // active dimension: 0 reads as 1, saturate at MAX_DIM
  logic [DIM_W-1:0] dim_cfg;
  logic [CNT_W-1:0] total_cfg;

  always_comb begin
    if (size_q == '0) begin
      dim_cfg = DIM_W'(1);
    end else if ({1'b0, size_q} > (SIZE_W + 1)'(MAX_DIM)) begin
      dim_cfg = DIM_W'(MAX_DIM);
    end else begin
      dim_cfg = DIM_W'(size_q);
    end
  end

  assign total_cfg = CNT_W'(CNT_W'(dim_cfg) * CNT_W'(dim_cfg));

  // ---------------------------------------------------------------------
  // Sequencer state
  // ---------------------------------------------------------------------
  state_e           state_q, state_d;
  logic [CNT_W-1:0] load_cnt_q, load_cnt_d;
  logic             cur_q, cur_d;        // product store holding the running product
  logic [EXP_W-1:0] iter_q, iter_d;      // multiply passes left
  logic [DIM_W-1:0] n_q, n_d;
  logic [CNT_W-1:0] total_q, total_d;
  logic             ident_q, ident_d;
  logic [IW-1:0]    r_q, r_d, c_q, c_d, k_q, k_d;
  logic [CNT_W-1:0] e_q, e_d;            // emit index
  logic [IW-1:0]    er_q, er_d, ec_q, ec_d;

  // MAC pipeline
  logic             v1_q, v2_q;
  logic             f1_q, l1_q, f2_q, l2_q;
  logic [AW-1:0]    wa1_q, wa2_q;
  logic [ELEM_W-1:0] mul_q, acc_q, acc_d;

  // output register
  logic              m_valid_q, m_valid_d;
  logic [ELEM_W-1:0] m_data_q, m_data_d;
  logic              m_last_q, m_last_d;

  // memory ports
  logic              base_we;
  logic [AW-1:0]     base_waddr, base_raddr, prod_waddr, prod_raddr;
  logic [ELEM_W-1:0] prod_wdata, base_rdata, prod0_rdata, prod1_rdata, left_rdata;
  logic              prod0_we, prod1_we;

  // load side
  logic              in_xfer;
  logic [CNT_W-1:0]  load_idx, load_inc;

  // MAC issue
  logic              k_last, c_last, r_last, issue;

  // emission
  logic              out_load, e_last, er_last_col;
  logic [CNT_W-1:0]  e_inc;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  assign load_idx = (load_cnt_q >= total_cfg) ? '0 : load_cnt_q;
  assign load_inc = load_idx + CNT_W'(1);

  assign issue  = (state_q == ST_MUL);
  assign k_last = (DIM_W'(k_q) == n_q - DIM_W'(1));
  assign c_last = (DIM_W'(c_q) == n_q - DIM_W'(1));
  assign r_last = (DIM_W'(r_q) == n_q - DIM_W'(1));

  assign left_rdata = cur_q ? prod1_rdata : prod0_rdata;

  assign out_load    = (state_q == ST_EMIT) && (!m_valid_q || m_axis_tready);
  assign e_inc       = e_q + CNT_W'(1);
  assign e_last      = (e_inc == total_q);
  assign er_last_col = (DIM_W'(ec_q) == n_q - DIM_W'(1));

  // accumulator: restart on the first k of each dot product
  assign acc_d = f2_q ? mul_q : acc_q + mul_q;

  // ---------------------------------------------------------------------
  // Memory addressing
  // ---------------------------------------------------------------------
  always_comb begin
    base_we    = in_xfer;
    base_waddr = load_idx[AW-1:0];
    prod0_we   = 1'b0;
    prod1_we   = 1'b0;
    prod_waddr = wa2_q;
    prod_wdata = acc_d;
    base_raddr = lin_addr(k_q, c_q, n_q);
    prod_raddr = lin_addr(r_q, k_q, n_q);
    if (in_xfer) begin
      // running product starts as A: load writes the base store and product store 0
      prod0_we   = 1'b1;
      prod_waddr = load_idx[AW-1:0];
      prod_wdata = s_axis_tdata;
    end else if (v2_q && l2_q) begin
      prod0_we = cur_q;
      prod1_we = !cur_q;
    end
    if (state_q == ST_PRIME || state_q == ST_EMIT) begin
      prod_raddr = out_load ? e_inc[AW-1:0] : e_q[AW-1:0];
    end
  end

  imp_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_base_ram (
    .clk_i   (clk_i),
    .we_i    (base_we),
    .waddr_i (base_waddr),
    .wdata_i (s_axis_tdata),
    .raddr_i (base_raddr),
    .rdata_o (base_rdata)
  );

  imp_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_prod0_ram (
    .clk_i   (clk_i),
    .we_i    (prod0_we),
    .waddr_i (prod_waddr),
    .wdata_i (prod_wdata),
    .raddr_i (prod_raddr),
    .rdata_o (prod0_rdata)
  );

  imp_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_prod1_ram (
    .clk_i   (clk_i),
    .we_i    (prod1_we),
    .waddr_i (prod_waddr),
    .wdata_i (prod_wdata),
    .raddr_i (prod_raddr),
    .rdata_o (prod1_rdata)
  );

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_d    = state_q;
    load_cnt_d = load_cnt_q;
    cur_d      = cur_q;
    iter_d     = iter_q;
    n_d        = n_q;
    total_d    = total_q;
    ident_d    = ident_q;
    r_d        = r_q;
    c_d        = c_q;
    k_d        = k_q;
    e_d        = e_q;
    er_d       = er_q;
    ec_d       = ec_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (load_inc == total_cfg) begin
            // matrix complete: latch shape and exponent, start the power
            load_cnt_d = '0;
            n_d        = dim_cfg;
            total_d    = total_cfg;
            ident_d    = (exp_q == '0);
            cur_d      = 1'b0;
            iter_d     = exp_q - EXP_W'(1);
            r_d        = '0;
            c_d        = '0;
            k_d        = '0;
            e_d        = '0;
            er_d       = '0;
            ec_d       = '0;
            state_d    = (exp_q > EXP_W'(1)) ? ST_MUL : ST_PRIME;
          end else begin
            load_cnt_d = load_inc;
          end
        end
      end
      ST_MUL: begin
        k_d = k_last ? '0 : k_q + IW'(1);
        if (k_last) begin
          c_d = c_last ? '0 : c_q + IW'(1);
          if (c_last) begin
            r_d = r_last ? '0 : r_q + IW'(1);
            if (r_last) begin
              state_d = ST_DRAIN;
            end
          end
        end
      end
      ST_DRAIN: begin
        if (!v1_q && !v2_q) begin
          cur_d   = !cur_q;
          iter_d  = iter_q - EXP_W'(1);
          state_d = (iter_q == EXP_W'(1)) ? ST_PRIME : ST_MUL;
        end
      end
      ST_PRIME: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_load) begin
          e_d  = e_inc;
          ec_d = er_last_col ? '0 : ec_q + IW'(1);
          er_d = er_last_col ? er_q + IW'(1) : er_q;
          if (e_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // output register
  always_comb begin
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    m_last_d  = m_last_q;
    if (out_load) begin
      m_valid_d = 1'b1;
      m_data_d  = ident_q ? ELEM_W'(er_q == ec_q) : left_rdata;
      m_last_d  = e_last;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      load_cnt_q <= '0;
      cur_q      <= 1'b0;
      iter_q     <= '0;
      n_q        <= DIM_W'(1);
      total_q    <= CNT_W'(1);
      ident_q    <= 1'b0;
      r_q        <= '0;
      c_q        <= '0;
      k_q        <= '0;
      e_q        <= '0;
      er_q       <= '0;
      ec_q       <= '0;
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      load_cnt_q <= load_cnt_d;
      cur_q      <= cur_d;
      iter_q     <= iter_d;
      n_q        <= n_d;
      total_q    <= total_d;
      ident_q    <= ident_d;
      r_q        <= r_d;
      c_q        <= c_d;
      k_q        <= k_d;
      e_q        <= e_d;
      er_q       <= er_d;
      ec_q       <= ec_d;
      v1_q       <= issue;
      v2_q       <= v1_q;
      m_valid_q  <= m_valid_d;
    end
  end

  // datapath payload
  always_ff @(posedge clk_i) begin
    // stage 1: read data arrives next cycle
    f1_q  <= (k_q == '0);
    l1_q  <= k_last;
    wa1_q <= lin_addr(r_q, c_q, n_q);
    // stage 2: product, low 32 bits
    f2_q  <= f1_q;
    l2_q  <= l1_q;
    wa2_q <= wa1_q;
    mul_q <= left_rdata * base_rdata;
    // stage 3: accumulate
    if (v2_q) begin
      acc_q <= acc_d;
    end
    m_data_q <= m_data_d;
    m_last_q <= m_last_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // MAC results are written only while a multiply pass is active
  a_mac_in_pass : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> (state_q == ST_MUL || state_q == ST_DRAIN))
    else $error("MAC pipeline busy outside a multiply pass");

  // a new pass never starts while the previous one still writes
  a_drain_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN && state_d != ST_DRAIN) |-> (!v1_q && !v2_q))
    else $error("pass ended with MAC pipeline not empty");

  // the emit index stays inside the result matrix
  a_emit_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (e_q < total_q))
    else $error("emit index beyond result matrix");

  // tlast is placed only as the emitter returns to idle
  a_last_ends : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && e_last) |=> (state_q == ST_IDLE && m_axis_tlast))
    else $error("last result not followed by idle");

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for integer_matrix_power_unit: streams square matrices in,
// predicts A^p per load and checks every streamed result element and its tlast.
// Depends on imp_pkg and the integer_matrix_power_unit RTL only.
`timescale 1ns / 100ps

module tb_top;
  import imp_pkg::*;

  localparam int unsigned DIM_MAX       = 8;
  localparam int unsigned CELLS         = DIM_MAX * DIM_MAX;
  localparam int unsigned RANDOM_ITEMS  = 350;
  localparam int unsigned SETTLE_CYCLES = 16;      // block idle well before this
  localparam int unsigned STALL_LIMIT   = 600000;  // long enough for the 8x8 run at p=255
  localparam int unsigned REPORT_MAX    = 10;

  // one expected result transfer
  typedef struct packed {
    logic [ELEM_W-1:0] value;
    logic              last;
  } power_elem_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic                  cfg_we   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic              elem_valid = 1'b0;
  logic              elem_ready;
  logic [ELEM_W-1:0] elem_data  = '0;
  logic              res_valid;
  logic              res_ready  = 1'b0;
  logic [ELEM_W-1:0] res_data;
  logic              res_last;

  integer_matrix_power_unit #(
    .MAX_DIM(DIM_MAX)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .s_axis_tvalid(elem_valid),
    .s_axis_tready(elem_ready),
    .s_axis_tdata (elem_data),
    .m_axis_tvalid(res_valid),
    .m_axis_tready(res_ready),
    .m_axis_tdata (res_data),
    .m_axis_tlast (res_last)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: register mirrors, loaded matrix, fill position.
  // ---------------------------------------------------------------------------
  logic [SIZE_W-1:0] size_cfg  = SIZE_RESET;
  logic [EXP_W-1:0]  power_cfg = EXP_RESET;
  logic [ELEM_W-1:0] a_matrix [CELLS];
  int unsigned       a_fill    = 0;

  power_elem_t       power_results_q [$];
  power_elem_t       want;
  logic [ELEM_W-1:0] pending_elems [$];

  int unsigned queued_count = 0;  // elements handed to the driver
  int unsigned taken_count  = 0;  // element transfers seen on the input
  int unsigned fail_count   = 0;
  int unsigned stall_cycles = 0;
  logic        elem_taken   = 1'b0;
  logic        calm         = 1'b0;  // no idling on either side while set

  // size 0 reads as 1, anything past DIM_MAX saturates
  function automatic int unsigned dim_of(input logic [SIZE_W-1:0] sz);
    if (sz == '0) return 1;
    if (sz > DIM_MAX) return DIM_MAX;
    return sz;
  endfunction

  // Takes one element into the matrix; a completing element produces A^p,
  // all products wrapping at 32 bits.
  task automatic absorb_element(input logic [ELEM_W-1:0] elem);
    int unsigned       n, total, r, c, k, pass;
    logic [ELEM_W-1:0] prod   [CELLS];
    logic [ELEM_W-1:0] step_m [CELLS];
    logic [ELEM_W-1:0] acc;
    n     = dim_of(size_cfg);
    total = n * n;
    // fill already past a shrunk size: partial load is dropped
    if (a_fill >= total) a_fill = 0;
    a_matrix[a_fill] = elem;
    a_fill++;
    if (a_fill < total) return;
    a_fill = 0;
    if (power_cfg == '0) begin
      for (r = 0; r < total; r++) prod[r] = '0;
      for (r = 0; r < n; r++) prod[r * n + r] = 1;
    end else begin
      for (r = 0; r < total; r++) prod[r] = a_matrix[r];
      for (pass = 1; pass < power_cfg; pass++) begin
        for (r = 0; r < n; r++) begin
          for (c = 0; c < n; c++) begin
            acc = '0;
            for (k = 0; k < n; k++) acc = acc + prod[r * n + k] * a_matrix[k * n + c];
            step_m[r * n + c] = acc;
          end
        end
        for (r = 0; r < total; r++) prod[r] = step_m[r];
      end
    end
    for (r = 0; r < total; r++) power_results_q.push_back('{value: prod[r], last: r == total - 1});
  endtask

  task automatic flag_mismatch(input string what, input logic [ELEM_W-1:0] exp_v, got_v);
    fail_count++;
    if (fail_count <= REPORT_MAX)
      $display("%0t: mismatch on %0s: expected %h, got %h", $time, what, exp_v, got_v);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: new element or idle at the falling edge; a pending transfer holds.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    res_ready <= calm || ($urandom_range(99) >= 24);
    if (elem_valid && !elem_taken) begin
      // hold until the transfer completes
    end else if (pending_elems.size() != 0 && (calm || $urandom_range(99) >= 24)) begin
      elem_valid <= 1'b1;
      elem_data  <= pending_elems.pop_front();
    end else begin
      elem_valid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: result check, input prediction and stall watchdog at the rising edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    elem_taken <= elem_valid && elem_ready;
    if (rst_ni) begin
      if ((elem_valid && elem_ready) || (res_valid && res_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles == STALL_LIMIT) begin
        $display("integer_matrix_power_unit verification failed");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end

      if (res_valid && res_ready) begin
        if (power_results_q.size() == 0) begin
          flag_mismatch("unexpected result transfer", 'x, res_data);
        end else begin
          want = power_results_q.pop_front();
          if (res_data !== want.value) flag_mismatch("result_value", want.value, res_data);
          if (res_last !== want.last) flag_mismatch("last_element", ELEM_W'(want.last),
                                                    ELEM_W'(res_last));
        end
      end

      if (elem_valid && elem_ready) begin
        taken_count++;
        absorb_element(elem_data);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    if (idx == REG_MATRIX_SIZE) size_cfg = val[SIZE_W-1:0];
    else if (idx == REG_EXPONENT) power_cfg = val[EXP_W-1:0];
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_elem(input logic [ELEM_W-1:0] v);
    pending_elems.push_back(v);
    queued_count++;
  endtask

  // full random words, with small values and the extremes mixed in
  function automatic logic [ELEM_W-1:0] rand_elem();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 65) return $urandom;
    if (pick < 88) return ELEM_W'($urandom_range(6)) - 3;
    case ($urandom_range(3))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  task automatic queue_random(input int unsigned count);
    repeat (count) queue_elem(rand_elem());
  endtask

  // mostly small matrices; occasionally zero, the full size or a saturating size
  function automatic logic [SIZE_W-1:0] pick_size();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 6) return '0;
    if (pick < 70) return SIZE_W'($urandom_range(1, 3));
    if (pick < 92) return SIZE_W'($urandom_range(4, 5));
    if (pick < 97) return SIZE_W'($urandom_range(6, 8));
    return SIZE_W'($urandom_range(9, 15));
  endfunction

  // long exponent runs only on small matrices to bound the multiply time
  function automatic logic [EXP_W-1:0] pick_power(input int unsigned n);
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 10) return '0;
    if (pick < 20) return 1;
    if (pick < 85) return EXP_W'($urandom_range(2, 6));
    if (n > 3) return EXP_W'($urandom_range(7, 12));
    if (pick < 93) return EXP_W'($urandom_range(7, 254));
    return '1;
  endfunction

  // every queued element taken and every result in, then let the block go idle
  task automatic wait_settled();
    while (!(taken_count == queued_count && power_results_q.size() == 0)) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [SIZE_W-1:0] sz;
    int unsigned       n, total, part, phase, random_items;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: 2x2 at power 1 passes the extremes straight through
    queue_elem(32'h7FFF_FFFF);
    queue_elem(32'h8000_0000);
    queue_elem('0);
    queue_elem('1);
    wait_settled();

    // size 0 acts as 1x1; power 0 gives the identity
    set_reg(REG_MATRIX_SIZE, '0);
    set_reg(REG_EXPONENT, '0);
    queue_elem(32'h8000_0000);
    wait_settled();

    // highest power on scalars: sign flips and wrap to zero
    set_reg(REG_EXPONENT, CFG_DATA_W'(8'd255));
    queue_elem('1);
    queue_elem(32'h8000_0000);
    queue_elem(32'd3);
    wait_settled();

    // squaring the extremes wraps the accumulator
    set_reg(REG_MATRIX_SIZE, CFG_DATA_W'(2));
    set_reg(REG_EXPONENT, CFG_DATA_W'(2));
    queue_elem(32'h7FFF_FFFF);
    queue_elem(32'h8000_0000);
    queue_elem(32'h8000_0000);
    queue_elem(32'h7FFF_FFFF);
    wait_settled();

    // exponent changed halfway through a load: the late value counts
    set_reg(REG_EXPONENT, CFG_DATA_W'(3));
    queue_random(2);
    wait_settled();
    set_reg(REG_EXPONENT, '0);
    queue_random(2);
    wait_settled();

    // size shrunk below the fill level: partial load dropped, new load starts
    set_reg(REG_EXPONENT, CFG_DATA_W'(2));
    queue_random(3);
    wait_settled();
    set_reg(REG_MATRIX_SIZE, CFG_DATA_W'(1));
    queue_random(1);
    wait_settled();

    // size grown mid-load: filled positions kept, load runs to 3x3
    set_reg(REG_MATRIX_SIZE, CFG_DATA_W'(2));
    set_reg(REG_EXPONENT, CFG_DATA_W'(1));
    queue_random(2);
    wait_settled();
    set_reg(REG_MATRIX_SIZE, CFG_DATA_W'(3));
    queue_random(7);
    wait_settled();

    // random part opens with a saturating size and the slowest full case
    set_reg(REG_MATRIX_SIZE, CFG_DATA_W'(15));
    set_reg(REG_EXPONENT, CFG_DATA_W'(2));
    queue_random(CELLS);
    wait_settled();
    set_reg(REG_MATRIX_SIZE, CFG_DATA_W'(DIM_MAX));
    set_reg(REG_EXPONENT, '1);
    queue_random(CELLS);
    wait_settled();
    random_items = 2 * CELLS;

    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      calm = (phase >= 12 && phase < 24);
      sz    = pick_size();
      n     = dim_of(sz);
      total = n * n;
      set_reg(REG_MATRIX_SIZE, CFG_DATA_W'(sz));
      set_reg(REG_EXPONENT, CFG_DATA_W'(pick_power(n)));
      if (total > 1 && $urandom_range(99) < 15) begin
        // broken load: stop partway, resize, then finish at the new size
        part = $urandom_range(1, total - 1);
        queue_random(part);
        wait_settled();
        sz    = pick_size();
        n     = dim_of(sz);
        total = n * n;
        set_reg(REG_MATRIX_SIZE, CFG_DATA_W'(sz));
        set_reg(REG_EXPONENT, CFG_DATA_W'(pick_power(n)));
        random_items += part;
        part = (part >= total) ? total : total - part;
      end else begin
        part = total;
      end
      queue_random(part);
      random_items += part;
      wait_settled();
      phase++;
    end
    calm = 1'b0;

    wait_settled();
    if (fail_count == 0 && power_results_q.size() == 0) begin
      $display("integer_matrix_power_unit verification clean");
    end else begin
      $display("integer_matrix_power_unit verification failed");
    end
    $finish;
  end

endmodule

>>> integer_matrix_power_unit.f
hw/rtl/imp_pkg.sv
hw/rtl/imp_ram.sv
hw/rtl/integer_matrix_power_unit.sv
verif/tb_top.sv
